/* rtl/console_command_tokenizer_top_defines.svh */
// Assertion helpers for the tokenizer modules, used by the parser.
// Each use expects clk_i and rst_ni in scope.
`ifndef CONSOLE_COMMAND_TOKENIZER_TOP_DEFINES_SVH
`define CONSOLE_COMMAND_TOKENIZER_TOP_DEFINES_SVH

`define CCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define CCT_ASSERT_IMP(lbl, ante, cons, msg) \
  `CCT_ASSERT(lbl, (ante) |-> (cons), msg)

`define CCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CCT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/cct_pkg.sv */
package cct_pkg;

  localparam int unsigned NameCount = 8;
  localparam int unsigned NameMaxLen = 8;
  localparam int unsigned ArgOutCount = 4;
  localparam int unsigned ArgW = 16;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] NO_MATCH = 4'd8;

  // Names are right-justified: last character sits in byte 0.
  localparam logic [8*NameMaxLen-1:0] NAME_STR [NameCount] = '{
    "help", "list", "setcnt", "setvol", "save", "volt", "voltcode", "dacajt"
  };
  localparam logic [3:0] NAME_LEN [NameCount] = '{
    4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd4, 4'd8, 4'd6
  };

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CMD_LONG = 2'd1,
    ST_ARG_LONG = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } item_t;

  typedef struct packed {
    status_e                           status;
    logic [3:0]                        command_id;
    logic [2:0]                        arg_count;
    logic [ArgOutCount-1:0][ArgW-1:0]  args;
  } res_t;

endpackage

/* rtl/cct_in_if.sv */
interface cct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

/* rtl/cct_out_if.sv */
interface cct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  command_id;
  logic [2:0]  arg_count;
  logic [15:0] first_arg;
  logic [15:0] second_arg;
  logic [15:0] third_arg;
  logic [15:0] fourth_arg;

  modport source (
    output valid, output status, output command_id, output arg_count,
    output first_arg, output second_arg, output third_arg, output fourth_arg,
    input ready
  );
  modport sink (
    input valid, input status, input command_id, input arg_count,
    input first_arg, input second_arg, input third_arg, input fourth_arg,
    output ready
  );
endinterface

/* rtl/cct_lookup.sv */
module cct_lookup #(
  parameter int unsigned WORD_MAX = 10,
  parameter int unsigned LenW = 4
) (
  input  logic [7:0]      word_chars_i [WORD_MAX],
  input  logic [LenW-1:0] word_len_i,
  output logic [3:0]      command_id_o
);
  import cct_pkg::*;

  logic [7:0] pad [NameMaxLen];
  logic [NameCount-1:0] hit;

  // Bytes past the stored word never match a name of that length anyway.
  for (genvar k = 0; k < NameMaxLen; k++) begin : g_pad
    if (k < WORD_MAX) begin : g_use
      assign pad[k] = word_chars_i[k];
    end else begin : g_zero
      assign pad[k] = 8'h00;
    end
  end

  always_comb begin
    for (int i = 0; i < NameCount; i++) begin
      hit[i] = (5'(word_len_i) == 5'(NAME_LEN[i]));
      for (int k = 0; k < NameMaxLen; k++) begin
        if (k < int'(NAME_LEN[i])) begin
          hit[i] = hit[i] &&
                   (pad[k] == NAME_STR[i][8*(int'(NAME_LEN[i])-1-k) +: 8]);
        end
      end
    end
  end

  always_comb begin
    command_id_o = NO_MATCH;
    for (int i = NameCount - 1; i >= 0; i--) begin
      if (hit[i]) begin
        command_id_o = 4'(i);
      end
    end
  end

endmodule

/* rtl/cct_parser.sv */
`include "console_command_tokenizer_top_defines.svh"

module cct_parser #(
  parameter int unsigned WORD_MAX = 10,
  parameter int unsigned ARG_MAX_COUNT = 4,
  parameter int unsigned ARG_MAX_CHARS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_vld_i,
  input  cct_pkg::item_t item_i,
  output logic           res_vld_o,
  output cct_pkg::res_t  res_o
);
  import cct_pkg::*;

  localparam int unsigned LenW  = $clog2(WORD_MAX + 1);
  localparam int unsigned WIdxW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int unsigned TokW  = $clog2(ARG_MAX_COUNT + 2);
  localparam int unsigned AIdxW = (ARG_MAX_COUNT > 1) ? $clog2(ARG_MAX_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(ARG_MAX_CHARS + 1);

  logic [7:0]      word_q [WORD_MAX];
  logic [ArgW-1:0] argv_q [ARG_MAX_COUNT];

  logic [LenW-1:0] word_len_q, word_len_d;
  logic [TokW-1:0] tok_idx_q, tok_idx_d;
  logic            blank_q, blank_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ArgW-1:0] acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            stop_q, stop_d;
  status_e         err_q, err_d;

  logic            word_we, arg_we;
  logic [TokW-1:0] eff_tok;
  logic [CntW-1:0] eff_cnt;
  logic [ArgW-1:0] eff_acc;
  logic            eff_neg, eff_stop;
  logic            go;
  logic            is_blank;
  logic [7:0]      ch;
  logic [7:0]      digit;
  logic [ArgW-1:0] arg_val;
  logic [3:0]      cmd_id;
  status_e         fin_err;
  logic [ArgOutCount-1:0][ArgW-1:0] end_args;

  cct_lookup #(
    .WORD_MAX(WORD_MAX),
    .LenW    (LenW)
  ) u_lookup (
    .word_chars_i(word_q),
    .word_len_i  (word_len_q),
    .command_id_o(cmd_id)
  );

  assign ch       = item_i.char_code;
  assign digit    = ch - CH_ZERO;
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign arg_val  = neg_q ? (~acc_q + 16'd1) : acc_q;

  // The last argument is still in the accumulator at line end.
  for (genvar j = 0; j < ArgOutCount; j++) begin : g_end_args
    if (j < ARG_MAX_COUNT) begin : g_arg
      always_comb begin
        end_args[j] = '0;
        if (TokW'(j) < tok_idx_q) begin
          end_args[j] = (tok_idx_q == TokW'(j + 1)) ? arg_val : argv_q[j];
        end
      end
    end else begin : g_none
      assign end_args[j] = '0;
    end
  end

  always_comb begin
    word_len_d = word_len_q;
    tok_idx_d  = tok_idx_q;
    blank_d    = blank_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    stop_d     = stop_q;
    err_d      = err_q;
    word_we    = 1'b0;
    arg_we     = 1'b0;
    eff_tok    = tok_idx_q;
    eff_cnt    = cnt_q;
    eff_acc    = acc_q;
    eff_neg    = neg_q;
    eff_stop   = stop_q;
    go         = 1'b1;
    fin_err    = err_q;
    res_vld_o  = 1'b0;
    res_o      = '0;
    res_o.command_id = NO_MATCH;

    if (item_vld_i) begin
      if (item_i.line_end) begin
        res_vld_o = 1'b1;
        if (err_q == ST_OK && tok_idx_q > TokW'(ARG_MAX_COUNT)) begin
          fin_err = ST_TOO_MANY;
        end
        res_o.status = fin_err;
        if (fin_err == ST_OK) begin
          res_o.command_id = cmd_id;
          res_o.arg_count  = 3'(tok_idx_q);
          res_o.args       = end_args;
        end
        word_len_d = '0;
        tok_idx_d  = '0;
        blank_d    = 1'b0;
        cnt_d      = '0;
        acc_d      = '0;
        neg_d      = 1'b0;
        stop_d     = 1'b0;
        err_d      = ST_OK;
      end else if (err_q == ST_OK) begin
        if (is_blank) begin
          blank_d = 1'b1;
        end else begin
          if (blank_q) begin
            // first byte of a new token closes the previous argument
            blank_d  = 1'b0;
            eff_cnt  = '0;
            eff_acc  = '0;
            eff_neg  = 1'b0;
            eff_stop = 1'b0;
            if (tok_idx_q != '0) begin
              if (tok_idx_q <= TokW'(ARG_MAX_COUNT)) begin
                arg_we = 1'b1;
              end else begin
                err_d = ST_TOO_MANY;
                go    = 1'b0;
              end
            end
            eff_tok = tok_idx_q + 1'b1;
          end
          if (go) begin
            tok_idx_d = eff_tok;
            cnt_d     = eff_cnt;
            acc_d     = eff_acc;
            neg_d     = eff_neg;
            stop_d    = eff_stop;
            if (eff_tok == '0) begin
              if (word_len_q < LenW'(WORD_MAX)) begin
                word_we    = 1'b1;
                word_len_d = word_len_q + 1'b1;
              end else begin
                err_d = ST_CMD_LONG;
              end
            end else if (eff_cnt < CntW'(ARG_MAX_CHARS)) begin
              if (!eff_stop) begin
                priority if (eff_cnt == '0 && (ch == CH_PLUS || ch == CH_MINUS)) begin
                  neg_d = (ch == CH_MINUS);
                end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                  acc_d = (eff_acc << 3) + (eff_acc << 1) + ArgW'(digit[3:0]);
                end else begin
                  stop_d = 1'b1;
                end
              end
              cnt_d = eff_cnt + 1'b1;
            end else begin
              err_d = ST_ARG_LONG;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q <= '0;
      tok_idx_q  <= '0;
      blank_q    <= 1'b0;
      cnt_q      <= '0;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      stop_q     <= 1'b0;
      err_q      <= ST_OK;
    end else begin
      word_len_q <= word_len_d;
      tok_idx_q  <= tok_idx_d;
      blank_q    <= blank_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      stop_q     <= stop_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_q[word_len_q[WIdxW-1:0]] <= ch;
    end
    if (arg_we) begin
      argv_q[AIdxW'(tok_idx_q - 1'b1)] <= arg_val;
    end
  end

  `CCT_ASSERT_NEXT(a_err_hold, err_q != ST_OK && !(item_vld_i && item_i.line_end), err_q == $past(err_q), "error code changed before line end")
  `CCT_ASSERT_NEXT(a_line_clear, item_vld_i && item_i.line_end, tok_idx_q == '0 && word_len_q == '0 && err_q == ST_OK && !blank_q, "parser not cleared after line end")
  `CCT_ASSERT_IMP(a_bounds, 1'b1, word_len_q <= LenW'(WORD_MAX) && tok_idx_q <= TokW'(ARG_MAX_COUNT + 1) && cnt_q <= CntW'(ARG_MAX_CHARS), "parser counter out of range")

endmodule

/* rtl/console_command_tokenizer_top.sv */
// Console line tokenizer: takes one byte per request on req_i and, when a request
// carries line_end, returns one result on rsp_o with status, command index, argument
// count and up to four 16-bit argument values. Every cycle one request can be taken
// unless a line end is stalled; a byte passes an input register, then the parser
// updates its token state, and a line end is written from the parser to the result
// register. The input register keeps taking bytes while a result waits on rsp_o;
// only a second line end stalls until that result is taken.
module console_command_tokenizer_top #(
  parameter int unsigned WORD_MAX = 10,
  parameter int unsigned ARG_MAX_COUNT = 4,
  parameter int unsigned ARG_MAX_CHARS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cct_in_if.sink           req_i,
  cct_out_if.source        rsp_o
);
  import cct_pkg::*;

  logic  in_vld_q;
  item_t in_item_q;
  logic  advance;
  logic  res_vld;
  res_t  res;
  logic  out_vld_q;
  res_t  out_q;

  assign advance   = in_vld_q && (!in_item_q.line_end || !out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_item_q.char_code <= req_i.char_code;
      in_item_q.line_end  <= req_i.line_end;
    end
  end

  cct_parser #(
    .WORD_MAX     (WORD_MAX),
    .ARG_MAX_COUNT(ARG_MAX_COUNT),
    .ARG_MAX_CHARS(ARG_MAX_CHARS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_vld_i(advance),
    .item_i    (in_item_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.command_id = out_q.command_id;
  assign rsp_o.arg_count  = out_q.arg_count;
  assign rsp_o.first_arg  = out_q.args[0];
  assign rsp_o.second_arg = out_q.args[1];
  assign rsp_o.third_arg  = out_q.args[2];
  assign rsp_o.fourth_arg = out_q.args[3];

endmodule
